// File: rtl/rvid_pkg.sv
// rvid_pkg: shared types and constants for the RV32IM instruction decoder.
// Opcode, funct7 and mnemonic codes plus the decoded word struct.
// No dependencies.
package rvid_pkg;

	// Major opcodes, bits 6..0
	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [6:0] OPC_FENCE  = 7'b0001111;

	localparam logic [6:0] F7_BASE   = 7'b0000000;
	localparam logic [6:0] F7_ALT    = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

	// Dense mnemonic numbers
	localparam logic [5:0] MN_ECALL  = 6'd0;
	localparam logic [5:0] MN_EBREAK = 6'd1;
	localparam logic [5:0] MN_ADD    = 6'd2;
	localparam logic [5:0] MN_SUB    = 6'd3;
	localparam logic [5:0] MN_SLL    = 6'd4;
	localparam logic [5:0] MN_SLT    = 6'd5;
	localparam logic [5:0] MN_SLTU   = 6'd6;
	localparam logic [5:0] MN_XOR    = 6'd7;
	localparam logic [5:0] MN_SRL    = 6'd8;
	localparam logic [5:0] MN_SRA    = 6'd9;
	localparam logic [5:0] MN_OR     = 6'd10;
	localparam logic [5:0] MN_AND    = 6'd11;
	localparam logic [5:0] MN_MUL    = 6'd12;
	localparam logic [5:0] MN_MULH   = 6'd13;
	localparam logic [5:0] MN_MULHSU = 6'd14;
	localparam logic [5:0] MN_MULHU  = 6'd15;
	localparam logic [5:0] MN_DIV    = 6'd16;
	localparam logic [5:0] MN_DIVU   = 6'd17;
	localparam logic [5:0] MN_REM    = 6'd18;
	localparam logic [5:0] MN_REMU   = 6'd19;
	localparam logic [5:0] MN_CSRRW  = 6'd20;
	localparam logic [5:0] MN_CSRRS  = 6'd21;
	localparam logic [5:0] MN_CSRRC  = 6'd22;
	localparam logic [5:0] MN_CSRRWI = 6'd23;
	localparam logic [5:0] MN_CSRRSI = 6'd24;
	localparam logic [5:0] MN_CSRRCI = 6'd25;
	localparam logic [5:0] MN_LB     = 6'd26;
	localparam logic [5:0] MN_LH     = 6'd27;
	localparam logic [5:0] MN_LW     = 6'd28;
	localparam logic [5:0] MN_LBU    = 6'd29;
	localparam logic [5:0] MN_LHU    = 6'd30;
	localparam logic [5:0] MN_SB     = 6'd31;
	localparam logic [5:0] MN_SH     = 6'd32;
	localparam logic [5:0] MN_SW     = 6'd33;
	localparam logic [5:0] MN_BEQ    = 6'd34;
	localparam logic [5:0] MN_BNE    = 6'd35;
	localparam logic [5:0] MN_BLT    = 6'd36;
	localparam logic [5:0] MN_BGE    = 6'd37;
	localparam logic [5:0] MN_BLTU   = 6'd38;
	localparam logic [5:0] MN_BGEU   = 6'd39;
	localparam logic [5:0] MN_LUI    = 6'd40;
	localparam logic [5:0] MN_AUIPC  = 6'd41;
	localparam logic [5:0] MN_ADDI   = 6'd42;
	localparam logic [5:0] MN_SLTI   = 6'd43;
	localparam logic [5:0] MN_SLTIU  = 6'd44;
	localparam logic [5:0] MN_XORI   = 6'd45;
	localparam logic [5:0] MN_ORI    = 6'd46;
	localparam logic [5:0] MN_ANDI   = 6'd47;
	localparam logic [5:0] MN_SLLI   = 6'd48;
	localparam logic [5:0] MN_SRLI   = 6'd49;
	localparam logic [5:0] MN_SRAI   = 6'd50;
	localparam logic [5:0] MN_JAL    = 6'd51;
	localparam logic [5:0] MN_JALR   = 6'd52;
	localparam logic [5:0] MN_FENCE  = 6'd53;
	localparam logic [5:0] MN_FENCEI = 6'd54;

	typedef struct packed {
		logic [5:0]         mnem;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic [11:0]        csr;
		logic signed [31:0] imm;
		logic               illegal;
	} dec_res_t;

endpackage

// File: rtl/rvid_decode.sv
// rvid_decode: combinational decode of one RV32IM word into a dec_res_t.
// Depends on rvid_pkg.
module rvid_decode (
	input  logic [31:0]        word,
	output rvid_pkg::dec_res_t res
);
	import rvid_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
	logic        ok;
	dec_res_t    d;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];

	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_u = {word[31:12], 12'b0};
	assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

	always_comb begin
		d         = '0;
		ok        = 1'b1;
		if (word == WORD_ECALL) begin
			d.mnem = MN_ECALL;
		end else if (word == WORD_EBREAK) begin
			d.mnem = MN_EBREAK;
		end else begin
			unique case (opc)
				OPC_REG: begin
					d.rd  = word[11:7];
					d.rs1 = word[19:15];
					d.rs2 = word[24:20];
					if (f7 == F7_BASE) begin
						unique case (f3)
							3'd0: d.mnem = MN_ADD;
							3'd1: d.mnem = MN_SLL;
							3'd2: d.mnem = MN_SLT;
							3'd3: d.mnem = MN_SLTU;
							3'd4: d.mnem = MN_XOR;
							3'd5: d.mnem = MN_SRL;
							3'd6: d.mnem = MN_OR;
							default: d.mnem = MN_AND;
						endcase
					end else if (f7 == F7_ALT && f3 == 3'd0) begin
						d.mnem = MN_SUB;
					end else if (f7 == F7_ALT && f3 == 3'd5) begin
						d.mnem = MN_SRA;
					end else if (f7 == F7_MULDIV) begin
						unique case (f3)
							3'd0: d.mnem = MN_MUL;
							3'd1: d.mnem = MN_MULH;
							3'd2: d.mnem = MN_MULHSU;
							3'd3: d.mnem = MN_MULHU;
							3'd4: d.mnem = MN_DIV;
							3'd5: d.mnem = MN_DIVU;
							3'd6: d.mnem = MN_REM;
							default: d.mnem = MN_REMU;
						endcase
					end else begin
						ok = 1'b0;
					end
				end
				OPC_SYSTEM: begin
					d.rd  = word[11:7];
					d.rs1 = word[19:15];
					d.csr = word[31:20];
					unique case (f3)
						3'd1: d.mnem = MN_CSRRW;
						3'd2: d.mnem = MN_CSRRS;
						3'd3: d.mnem = MN_CSRRC;
						3'd5: d.mnem = MN_CSRRWI;
						3'd6: d.mnem = MN_CSRRSI;
						3'd7: d.mnem = MN_CSRRCI;
						default: ok = 1'b0;  // funct3 0 other than ecall/ebreak, or 4
					endcase
				end
				OPC_LOAD: begin
					d.rd  = word[11:7];
					d.rs1 = word[19:15];
					d.imm = imm_i;
					unique case (f3)
						3'd0: d.mnem = MN_LB;
						3'd1: d.mnem = MN_LH;
						3'd2: d.mnem = MN_LW;
						3'd4: d.mnem = MN_LBU;
						3'd5: d.mnem = MN_LHU;
						default: ok = 1'b0;
					endcase
				end
				OPC_STORE: begin
					d.rs1 = word[19:15];
					d.rs2 = word[24:20];
					d.imm = imm_s;
					unique case (f3)
						3'd0: d.mnem = MN_SB;
						3'd1: d.mnem = MN_SH;
						3'd2: d.mnem = MN_SW;
						default: ok = 1'b0;
					endcase
				end
				OPC_BRANCH: begin
					d.rs1 = word[19:15];
					d.rs2 = word[24:20];
					d.imm = imm_b;
					unique case (f3)
						3'd0: d.mnem = MN_BEQ;
						3'd1: d.mnem = MN_BNE;
						3'd4: d.mnem = MN_BLT;
						3'd5: d.mnem = MN_BGE;
						3'd6: d.mnem = MN_BLTU;
						3'd7: d.mnem = MN_BGEU;
						default: ok = 1'b0;
					endcase
				end
				OPC_LUI: begin
					d.mnem = MN_LUI;
					d.rd   = word[11:7];
					d.imm  = imm_u;
				end
				OPC_AUIPC: begin
					d.mnem = MN_AUIPC;
					d.rd   = word[11:7];
					d.imm  = imm_u;
				end
				OPC_IMM: begin
					d.rd  = word[11:7];
					d.rs1 = word[19:15];
					unique case (f3)
						3'd1: begin
							d.rs2 = word[24:20];
							if (f7 == F7_BASE) d.mnem = MN_SLLI;
							else               ok = 1'b0;
						end
						3'd5: begin
							d.rs2 = word[24:20];
							if (f7 == F7_BASE)     d.mnem = MN_SRLI;
							else if (f7 == F7_ALT) d.mnem = MN_SRAI;
							else                   ok = 1'b0;
						end
						3'd0: begin d.mnem = MN_ADDI;  d.imm = imm_i; end
						3'd2: begin d.mnem = MN_SLTI;  d.imm = imm_i; end
						3'd3: begin d.mnem = MN_SLTIU; d.imm = imm_i; end
						3'd4: begin d.mnem = MN_XORI;  d.imm = imm_i; end
						3'd6: begin d.mnem = MN_ORI;   d.imm = imm_i; end
						default: begin d.mnem = MN_ANDI; d.imm = imm_i; end
					endcase
				end
				OPC_JAL: begin
					d.mnem = MN_JAL;
					d.rd   = word[11:7];
					d.imm  = imm_j;
				end
				OPC_JALR: begin
					d.mnem = MN_JALR;
					d.rd   = word[11:7];
					d.rs1  = word[19:15];
					d.imm  = imm_i;
					if (f3 != 3'd0) ok = 1'b0;
				end
				OPC_FENCE: begin
					if (f3 == 3'd0)      d.mnem = MN_FENCE;
					else if (f3 == 3'd1) d.mnem = MN_FENCEI;
					else                 ok = 1'b0;
				end
				default: ok = 1'b0;
			endcase
		end

		// unsupported encodings report only the flag
		if (ok) begin
			res = d;
		end else begin
			res         = '0;
			res.illegal = 1'b1;
		end
	end

endmodule

// File: rtl/rv32im_instruction_decoder.sv
// rv32im_instruction_decoder: top level, input word register, decoder and
// result register with valid/stall flow control. Depends on rvid_pkg, rvid_decode.
//
// Path: an accepted word waits in the input register (_s1), its result
//   (out_valid) in the result register (_s2). Throughput: one word per cycle
//   while out_stall is low; set by the single decode pass between them.
// Reset: arst_n clears both stage valid flags asynchronously; payload regs are
//   not reset.
module rv32im_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	// input word channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr_word,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         mnemonic_id,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [11:0]        csr_addr,
	output logic signed [31:0] imm_value,
	output logic               illegal
);
	import rvid_pkg::*;

	// stage 1: captured instruction word
	logic        valid_s1;
	logic [31:0] instr_s1;
	// stage 2: decoded result held for the consumer
	logic        valid_s2;
	dec_res_t    res_s2;

	dec_res_t    dec;
	logic        adv_s2;   // result register may take a new word
	logic        adv_s1;   // input register may take a new word

	rvid_decode u_decode (
		.word (instr_s1),
		.res  (dec)
	);

	// The result register frees up when empty or when its word leaves this
	// cycle; the input register frees up when empty or when it moves forward.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// payload: loaded only with a live word, otherwise held
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) instr_s1 <= instr_word;
		if (adv_s2 && valid_s1) res_s2   <= dec;
	end

	assign out_valid   = valid_s2;
	assign mnemonic_id = res_s2.mnem;
	assign dest_reg    = res_s2.rd;
	assign src1_reg    = res_s2.rs1;
	assign src2_reg    = res_s2.rs2;
	assign csr_addr    = res_s2.csr;
	assign imm_value   = res_s2.imm;
	assign illegal     = res_s2.illegal;

	// Back-pressure reaches the input only with both stages full and the
	// consumer stalling.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	// An illegal word carries no mnemonic and no immediate.
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && illegal) |-> (mnemonic_id == MN_ECALL && imm_value == 32'sd0
			&& dest_reg == 5'd0 && csr_addr == 12'd0))
		else $error("illegal word with nonzero fields");

	// Legal mnemonics stay within the dense range.
	a_mnem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !illegal) |-> (mnemonic_id <= MN_FENCEI))
		else $error("mnemonic out of range");

	// A CSR address appears only on the CSR forms.
	a_csr_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && csr_addr != 12'd0) |->
			(mnemonic_id >= MN_CSRRW && mnemonic_id <= MN_CSRRCI))
		else $error("CSR address on a non-CSR instruction");

	// Stores and branches have no destination register.
	a_no_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mnemonic_id >= MN_SB && mnemonic_id <= MN_BGEU) |->
			(dest_reg == 5'd0))
		else $error("store or branch with a destination register");

endmodule

// File: tb/sv/rvid_decode_check_pkg.sv
// rvid_decode_check_pkg: scoreboard for the RV32IM decoder bench. It decodes each accepted
// word on its own and checks the decoder's results in order.
// Depends on rvid_pkg.
package rvid_decode_check_pkg;
	import rvid_pkg::*;

	// marks an unlisted encoding inside the tables below
	localparam logic [5:0] MN_NONE = 6'h3F;
	localparam int MAX_PRINTED = 200;

	// mnemonic per funct3, funct3 = 0 is the rightmost entry
	localparam logic [7:0][5:0] BASE_MN = {MN_AND, MN_OR, MN_SRL, MN_XOR,
		MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
	localparam logic [7:0][5:0] ALT_MN = {MN_NONE, MN_NONE, MN_SRA, MN_NONE,
		MN_NONE, MN_NONE, MN_NONE, MN_SUB};
	localparam logic [7:0][5:0] MULDIV_MN = {MN_REMU, MN_REM, MN_DIVU, MN_DIV,
		MN_MULHU, MN_MULHSU, MN_MULH, MN_MUL};
	localparam logic [7:0][5:0] CSR_MN = {MN_CSRRCI, MN_CSRRSI, MN_CSRRWI, MN_NONE,
		MN_CSRRC, MN_CSRRS, MN_CSRRW, MN_NONE};
	localparam logic [7:0][5:0] LOAD_MN = {MN_NONE, MN_NONE, MN_LHU, MN_LBU,
		MN_NONE, MN_LW, MN_LH, MN_LB};
	localparam logic [7:0][5:0] STORE_MN = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
		MN_NONE, MN_SW, MN_SH, MN_SB};
	localparam logic [7:0][5:0] BRANCH_MN = {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT,
		MN_NONE, MN_NONE, MN_BNE, MN_BEQ};
	localparam logic [7:0][5:0] OPIMM_MN = {MN_ANDI, MN_ORI, MN_SRLI, MN_XORI,
		MN_SLTIU, MN_SLTI, MN_SLLI, MN_ADDI};
	localparam logic [7:0][5:0] FENCE_MN = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
		MN_NONE, MN_NONE, MN_FENCEI, MN_FENCE};

	class decode_checker;
		typedef struct {
			logic [31:0] word;
			dec_res_t    want;
		} pending_decode_t;

		pending_decode_t expected_decodes[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// full decode of one word; unused fields stay 0, unlisted encodings
		// give the illegal flag alone
		static function dec_res_t decode_word(logic [31:0] w);
			dec_res_t r;
			logic [2:0] f3;
			logic [6:0] f7;
			logic [31:0] i_imm;
			r = '0;
			f3 = w[14:12];
			f7 = w[31:25];
			i_imm = {{20{w[31]}}, w[31:20]};
			r.mnem = MN_NONE;
			if (w == WORD_ECALL) begin
				r.mnem = MN_ECALL;
			end else if (w == WORD_EBREAK) begin
				r.mnem = MN_EBREAK;
			end else begin
				case (w[6:0])
				OPC_REG: begin
					if (f7 == F7_BASE) r.mnem = BASE_MN[f3];
					else if (f7 == F7_ALT) r.mnem = ALT_MN[f3];
					else if (f7 == F7_MULDIV) r.mnem = MULDIV_MN[f3];
					r.rd = w[11:7];
					r.rs1 = w[19:15];
					r.rs2 = w[24:20];
				end
				OPC_SYSTEM: begin
					// funct3 0 here is neither ecall nor ebreak
					r.mnem = CSR_MN[f3];
					r.rd = w[11:7];
					r.rs1 = w[19:15];
					r.csr = w[31:20];
				end
				OPC_LOAD: begin
					r.mnem = LOAD_MN[f3];
					r.rd = w[11:7];
					r.rs1 = w[19:15];
					r.imm = i_imm;
				end
				OPC_STORE: begin
					r.mnem = STORE_MN[f3];
					r.rs1 = w[19:15];
					r.rs2 = w[24:20];
					r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				end
				OPC_BRANCH: begin
					r.mnem = BRANCH_MN[f3];
					r.rs1 = w[19:15];
					r.rs2 = w[24:20];
					r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				end
				OPC_LUI, OPC_AUIPC: begin
					r.mnem = (w[6:0] == OPC_LUI) ? MN_LUI : MN_AUIPC;
					r.rd = w[11:7];
					r.imm = {w[31:12], 12'b0};
				end
				OPC_IMM: begin
					r.mnem = OPIMM_MN[f3];
					r.rd = w[11:7];
					r.rs1 = w[19:15];
					if (r.mnem == MN_SLLI) begin
						if (f7 != F7_BASE) r.mnem = MN_NONE;
						r.rs2 = w[24:20];
					end else if (r.mnem == MN_SRLI) begin
						if (f7 == F7_ALT) r.mnem = MN_SRAI;
						else if (f7 != F7_BASE) r.mnem = MN_NONE;
						r.rs2 = w[24:20];
					end else begin
						r.imm = i_imm;
					end
				end
				OPC_JAL: begin
					r.mnem = MN_JAL;
					r.rd = w[11:7];
					r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				end
				OPC_JALR: begin
					if (f3 == '0) r.mnem = MN_JALR;
					r.rd = w[11:7];
					r.rs1 = w[19:15];
					r.imm = i_imm;
				end
				OPC_FENCE: begin
					r.mnem = FENCE_MN[f3];
				end
				default: begin
				end
				endcase
			end
			if (r.mnem == MN_NONE) begin
				r = '0;
				r.illegal = 1'b1;
			end
			return r;
		endfunction

		function int pending();
			return expected_decodes.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED) $display("ERROR %s", msg);
		endtask

		task check_field(logic [31:0] word, string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("word %h: %s is %0h, expected %0h", word, name, got, want));
		endtask

		task note_word(logic [31:0] w);
			pending_decode_t p;
			p.word = w;
			p.want = decode_word(w);
			expected_decodes = {expected_decodes, p};
		endtask

		task check_result(dec_res_t got);
			pending_decode_t p;
			if (expected_decodes.size() == 0) begin
				report($sformatf("result %h arrived with no word pending", got));
			end else begin
				p = expected_decodes.pop_front();
				check_field(p.word, "mnemonic_id", 32'(got.mnem), 32'(p.want.mnem));
				check_field(p.word, "dest_reg", 32'(got.rd), 32'(p.want.rd));
				check_field(p.word, "src1_reg", 32'(got.rs1), 32'(p.want.rs1));
				check_field(p.word, "src2_reg", 32'(got.rs2), 32'(p.want.rs2));
				check_field(p.word, "csr_addr", 32'(got.csr), 32'(p.want.csr));
				check_field(p.word, "imm_value", got.imm, p.want.imm);
				check_field(p.word, "illegal", 32'(got.illegal), 32'(p.want.illegal));
			end
		endtask

		task flag_leftovers();
			foreach (expected_decodes[i])
				report($sformatf("word %h never got a result", expected_decodes[i].word));
		endtask
	endclass

endpackage

// File: tb/sv/rv32im_instruction_decoder_test.sv
// rv32im_instruction_decoder_test: top of the decoder bench. Drives words with random
// gaps, stalls the result side at random and checks every result against the scoreboard.
// Depends on rvid_pkg, rvid_decode_check_pkg and the rv32im_instruction_decoder RTL.
module rv32im_instruction_decoder_test;
	import rvid_pkg::*;
	import rvid_decode_check_pkg::*;

	localparam int RANDOM_WORDS   = 450;
	localparam int GAP_PCT        = 21;    // idle / stall rate on each side
	localparam int NOISE_PCT      = 12;    // fully random words in the random part
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES  = 4;     // two-stage pipe, plus margin

	// opcodes the random part builds well-formed words from
	localparam logic [10:0][6:0] OPCODES = {OPC_REG, OPC_LOAD, OPC_STORE, OPC_BRANCH,
		OPC_JAL, OPC_JALR, OPC_IMM, OPC_LUI, OPC_AUIPC, OPC_SYSTEM, OPC_FENCE};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        instr_word;
	logic               out_valid;
	logic               out_stall;
	logic [5:0]         mnemonic_id;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [11:0]        csr_addr;
	logic signed [31:0] imm_value;
	logic               illegal;

	// set during the stretch where neither side idles
	logic no_gaps;
	int   quiet_cycles;

	decode_checker chk;

	rv32im_instruction_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.instr_word  (instr_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mnemonic_id (mnemonic_id),
		.dest_reg    (dest_reg),
		.src1_reg    (src1_reg),
		.src2_reg    (src2_reg),
		.csr_addr    (csr_addr),
		.imm_value   (imm_value),
		.illegal     (illegal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one random draw per cycle and side, off entirely in the no-gap stretch
	function automatic bit gap_now();
		return !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
	endfunction

	// plain field packing, R/I/S/B layout
	function automatic logic [31:0] field_word(logic [6:0] f7, logic [4:0] rs2,
			logic [4:0] rs1, logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// Mostly well-formed words with random fields: funct7 steered toward the listed
	// values, ecall/ebreak forced now and then, jalr and fence funct3 biased legal.
	// The rest is raw noise, which covers unknown opcodes.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 99) < NOISE_PCT)
			return w;
		w[6:0] = OPCODES[$urandom_range(0, 10)];
		case (w[6:0])
		OPC_REG, OPC_IMM: begin
			case ($urandom_range(0, 3))
			0: w[31:25] = F7_BASE;
			1: w[31:25] = F7_ALT;
			2: w[31:25] = (w[6:0] == OPC_REG) ? F7_MULDIV : F7_BASE;
			default: begin
			end
			endcase
		end
		OPC_SYSTEM: begin
			case ($urandom_range(0, 4))
			0: w = WORD_ECALL;
			1: w = WORD_EBREAK;
			default: begin
			end
			endcase
		end
		OPC_JALR: if ($urandom_range(0, 3) != 0) w[14:12] = '0;
		OPC_FENCE: if ($urandom_range(0, 2) != 0) w[14:13] = '0;
		default: begin
		end
		endcase
		return w;
	endfunction

	// Presents one word from a falling edge and holds it until the decoder
	// takes it. Returns right after the accepting rising edge.
	task automatic send_word(logic [31:0] w);
		@(negedge clk);
		while (gap_now()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		instr_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// holds off the sender until every outstanding word has its result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (chk.pending() != 0) @(negedge clk);
	endtask

	// Result side: stall decided fresh at every falling edge.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			out_stall <= gap_now();
		end
	end

	// Monitor: both handshakes are sampled at the rising edge, input first.
	// The watchdog restarts on any handshake.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			chk.note_word(instr_word);
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (arst_n && out_valid && !out_stall) begin
			chk.check_result(dec_res_t'({mnemonic_id, dest_reg, src1_reg, src2_reg,
				csr_addr, imm_value, illegal}));
			quiet_cycles = 0;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [31:0] directed_words[$];
		chk = new();
		quiet_cycles = 0;
		no_gaps = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		instr_word <= '0;

		// Directed words: field extremes, one per format, and the illegal corners
		// (all-zero and all-one words, system word with rd set, bad funct7 on
		// R-type and on shift-immediates, unlisted funct3 on loads, jalr, fence).
		directed_words = '{
			32'h0000_0000,
			32'hFFFF_FFFF,
			WORD_ECALL,
			WORD_EBREAK,
			field_word(F7_BASE, 5'd0, 5'd0, 3'd0, 5'd31, OPC_SYSTEM),
			field_word(F7_BASE, 5'd31, 5'd31, 3'd0, 5'd31, OPC_REG),
			field_word(F7_ALT, 5'd31, 5'd0, 3'd0, 5'd31, OPC_REG),
			field_word(F7_ALT, 5'd0, 5'd0, 3'd5, 5'd0, OPC_REG),
			field_word(F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, OPC_REG),
			field_word(F7_MULDIV, 5'd31, 5'd31, 3'd7, 5'd31, OPC_REG),
			{12'hFFF, 5'd31, 3'd7, 5'd31, OPC_SYSTEM},
			{12'h800, 5'd31, 3'd2, 5'd31, OPC_LOAD},
			{12'h7FF, 5'd0, 3'd5, 5'd1, OPC_LOAD},
			{12'h123, 5'd4, 3'd3, 5'd5, OPC_LOAD},
			field_word(7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OPC_STORE),
			field_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, OPC_BRANCH),
			field_word(7'h3F, 5'd0, 5'd0, 3'd0, 5'd31, OPC_BRANCH),
			{20'hFFFFF, 5'd31, OPC_LUI},
			{20'h80000, 5'd1, OPC_AUIPC},
			field_word(F7_ALT, 5'd31, 5'd31, 3'd5, 5'd31, OPC_IMM),
			field_word(F7_ALT, 5'd1, 5'd1, 3'd1, 5'd1, OPC_IMM),
			{12'hFFF, 5'd31, 3'd0, 5'd31, OPC_IMM},
			{1'b1, 10'h000, 1'b0, 8'h00, 5'd31, OPC_JAL},
			{12'hFFF, 5'd1, 3'd1, 5'd1, OPC_JALR},
			{12'hFFF, 5'd31, 3'd0, 5'd31, OPC_JALR},
			{4'h0, 4'hF, 4'hF, 5'd0, 3'd0, 5'd0, OPC_FENCE},
			{12'h000, 5'd0, 3'd1, 5'd0, OPC_FENCE},
			{12'h000, 5'd0, 3'd2, 5'd0, OPC_FENCE}
		};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_words[i])
			send_word(directed_words[i]);
		// sender waits for an empty pipe before the random part
		drain_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// back-to-back stretch on both sides
			no_gaps = (n >= 150 && n < 250);
			// second hold-off, in the middle of the random part
			if (n == 320) drain_results();
			send_word(random_word());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (chk.pending() != 0) @(negedge clk);
		// let any stray result show up
		repeat (SETTLE_CYCLES) @(negedge clk);

		chk.flag_leftovers();
		if (chk.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rvid_pkg.sv
rtl/rvid_decode.sv
rtl/rv32im_instruction_decoder.sv
tb/sv/rvid_decode_check_pkg.sv
tb/sv/rv32im_instruction_decoder_test.sv
